// ===== rtl/prs_pkg.sv =====
// Shared constants, codes and types of the polyphase resampler.
// Used by the interfaces, the controller, the datapath and the top level.
package prs_pkg;

   localparam int TAPS_DEFAULT           = 16;
   localparam int MAX_PHASES_DEFAULT     = 32;
   localparam int SAMPLE_DEPTH_DEFAULT   = 16384;
   localparam int COEF_FRAC_BITS_DEFAULT = 15;

   // field widths
   localparam int CMD_W   = 2;
   localparam int ADDR_W  = 14;
   localparam int VALUE_W = 16;
   localparam int MSTEP_W = 8;
   localparam int LREG_W  = 6;
   localparam int PH_W    = 7;   // clamped phase count, at most 63 and at most MAX_PHASES
   localparam int LOOP_W  = 14;
   localparam int LEN_W   = 15;
   localparam int OIDX_W  = 24;
   localparam int IIDX_W  = 15;
   localparam int PROD_W  = OIDX_W + MSTEP_W;
   localparam int WPROD_W = LOOP_W + PH_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   // item commands
   localparam logic [CMD_W-1:0] CMD_LOAD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_COEF   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NEXT        = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DECIMATION = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASES     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_MODE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_BEGIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_END   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH     = 3'd5;

   typedef struct packed {
      logic [MSTEP_W-1:0] decimation_step;
      logic [LREG_W-1:0]  interpolation_phases;
      logic               loop_mode;
      logic [LOOP_W-1:0]  loop_begin;
      logic [LOOP_W-1:0]  loop_end;
      logic [LEN_W-1:0]   sample_length;
   } cfg_type;

   typedef struct packed {
      logic ld_sample;
      logic ld_coef;
      logic restart;
      logic mul_m;
      logic div_prod;
      logic div_wrap;
      logic latch_nk;
      logic latch_k;
      logic mul_wrap;
      logic apply_wrap;
      logic rd_sample;
      logic shift_in;
      logic mac_clear;
      logic mac_step;
      logic scale;
      logic finish;
      logic stop_play;
      logic zero_res;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic playing;
      logic div_done;
      logic changed;
      logic wrap_needed;
      logic end_needed;
      logic mac_done;
      logic out_free;
   } dp_sts_type;

endpackage

// ===== rtl/prs_if.sv =====
// Channel interfaces of the polyphase resampler: request, response, register write.
// Depends on prs_pkg for field widths.
interface prs_req_if;
   logic                         valid;
   logic                         ready;
   logic [prs_pkg::CMD_W-1:0]    command;
   logic [prs_pkg::ADDR_W-1:0]   address;
   logic signed [prs_pkg::VALUE_W-1:0] value;
   modport source (output valid, command, address, value, input ready);
   modport sink   (input valid, command, address, value, output ready);
endinterface

interface prs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [prs_pkg::VALUE_W-1:0] out_sample;
   logic                               active;
   modport source (output valid, out_sample, active, input ready);
   modport sink   (input valid, out_sample, active, output ready);
endinterface

interface prs_csr_if;
   logic                              valid;
   logic                              ready;
   logic [prs_pkg::CSR_IDX_W-1:0]     index;
   logic [prs_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/polyphase_resampler.sv =====
// Top level of the polyphase resampler: register file, sequencer and datapath.
// Depends on prs_pkg, the prs interfaces, prs_ctrl and prs_dp.
//
// Usage:
//  - req_bus carries one item: command, address, value. Load sample and
//    load coefficient write the stores, restart rewinds playback; these
//    give no response.
//  - A next item yields exactly one response on rsp_bus: out_sample, active.
//    Once an unlooped play reaches the end, responses are 0 with active low
//    until restart.
//  - csr_bus writes one configuration register per cycle; always ready.
//    Write it only while the block is idle.
// A next item runs a multiply, a 32-bit restoring divide, the index check, the
// sample read and shift, a MAC pipeline, scaling and the output load; the read
// and shift are skipped when the input index holds. A loop wrap adds two
// divides and two multiplies. The unlooped end stops after the index check, an
// inactive next goes straight to the output load. One item at a time: a new
// item is accepted only once the last one has loaded its response.
// Reset restores the configuration registers, clears indices and the delay
// line and sets playback active; store contents are undefined until written.
// A stalled receiver holds the response register; a following load or
// restart is still accepted, a further next is computed and then waits.
module polyphase_resampler #(
   parameter int TAPS           = prs_pkg::TAPS_DEFAULT,
   parameter int MAX_PHASES     = prs_pkg::MAX_PHASES_DEFAULT,
   parameter int SAMPLE_DEPTH   = prs_pkg::SAMPLE_DEPTH_DEFAULT,
   parameter int COEF_FRAC_BITS = prs_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   prs_req_if.sink    req_bus,
   prs_rsp_if.source  rsp_bus,
   prs_csr_if.sink    csr_bus
);
   prs_pkg::cfg_type    cfg_ff, cfg_in;
   prs_pkg::dp_cmd_type dp_cmd;
   prs_pkg::dp_sts_type dp_sts;
   logic                req_ready;
   logic                req_fire;

   // configuration registers
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            prs_pkg::CSR_DECIMATION:
               cfg_in.decimation_step = csr_bus.data[prs_pkg::MSTEP_W-1:0];
            prs_pkg::CSR_PHASES:
               cfg_in.interpolation_phases = csr_bus.data[prs_pkg::LREG_W-1:0];
            prs_pkg::CSR_LOOP_MODE:  cfg_in.loop_mode  = csr_bus.data[0];
            prs_pkg::CSR_LOOP_BEGIN:
               cfg_in.loop_begin = csr_bus.data[prs_pkg::LOOP_W-1:0];
            prs_pkg::CSR_LOOP_END:
               cfg_in.loop_end = csr_bus.data[prs_pkg::LOOP_W-1:0];
            prs_pkg::CSR_LENGTH:
               cfg_in.sample_length = csr_bus.data[prs_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decimation_step      <= prs_pkg::MSTEP_W'(1);
         cfg_ff.interpolation_phases <= prs_pkg::LREG_W'(1);
         cfg_ff.loop_mode            <= 1'b0;
         cfg_ff.loop_begin           <= '0;
         cfg_ff.loop_end             <= '0;
         cfg_ff.sample_length        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_bus.ready = req_ready;
   assign req_fire      = req_bus.valid && req_ready;

   prs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_command (req_bus.command),
      .sts         (dp_sts),
      .req_ready   (req_ready),
      .cmd         (dp_cmd)
   );

   prs_dp #(
      .TAPS           (TAPS),
      .MAX_PHASES     (MAX_PHASES),
      .SAMPLE_DEPTH   (SAMPLE_DEPTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (dp_cmd),
      .ld_address (req_bus.address),
      .ld_value   (req_bus.value),
      .out_ready  (rsp_bus.ready),
      .sts        (dp_sts),
      .out_valid  (rsp_bus.valid),
      .out_sample (rsp_bus.out_sample),
      .out_active (rsp_bus.active)
   );

   // an ended play always reports silence
   a_inactive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.active |-> rsp_bus.out_sample == '0)
      else $error("inactive response with nonzero sample");

   // the response register is never overwritten while it still waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.out_load |-> dp_sts.out_free)
      else $error("response register overwritten");

   // restart always reactivates playback
   a_restart_plays: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.command == prs_pkg::CMD_RESTART |=> dp_sts.playing)
      else $error("restart did not reactivate playback");
endmodule

// ===== rtl/prs_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module prs_div #(
   parameter int DW = 32,
   parameter int VW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] q_ff, q_in;
   logic [VW-1:0] r_ff, r_in, d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      trial   = {r_ff, q_ff[DW-1]};
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = CW'(DW);
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = VW'(trial - {1'b0, d_ff});
            q_in = {q_ff[DW-2:0], 1'b1};
         end else begin
            r_in = trial[VW-1:0];
            q_in = {q_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;
endmodule

// ===== rtl/prs_ctrl.sv =====
// Sequencer of the polyphase resampler: walks one item through the datapath.
// Depends on prs_pkg for commands, command and status structs.
module prs_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_fire,
   input  logic [prs_pkg::CMD_W-1:0]  req_command,
   input  prs_pkg::dp_sts_type        sts,
   output logic                       req_ready,
   output prs_pkg::dp_cmd_type        cmd
);
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DIV1_GO   = 4'd1;
   localparam logic [3:0] S_DIV1_WAIT = 4'd2;
   localparam logic [3:0] S_CHECK     = 4'd3;
   localparam logic [3:0] S_DIV2_GO   = 4'd4;
   localparam logic [3:0] S_DIV2_WAIT = 4'd5;
   localparam logic [3:0] S_MUL3      = 4'd6;
   localparam logic [3:0] S_DIV3_GO   = 4'd7;
   localparam logic [3:0] S_DIV3_WAIT = 4'd8;
   localparam logic [3:0] S_SHIFT     = 4'd9;
   localparam logic [3:0] S_MAC       = 4'd10;
   localparam logic [3:0] S_FIN       = 4'd11;
   localparam logic [3:0] S_OUT       = 4'd12;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_command)
                  prs_pkg::CMD_LOAD_SAMPLE: cmd.ld_sample = 1'b1;
                  prs_pkg::CMD_LOAD_COEF:   cmd.ld_coef = 1'b1;
                  prs_pkg::CMD_RESTART:     cmd.restart = 1'b1;
                  prs_pkg::CMD_NEXT: begin
                     if (sts.playing) begin
                        cmd.mul_m = 1'b1;
                        state_in  = S_DIV1_GO;
                     end else begin
                        cmd.zero_res = 1'b1;
                        state_in     = S_OUT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIV1_GO: begin
            cmd.div_prod = 1'b1;
            state_in     = S_DIV1_WAIT;
         end
         S_DIV1_WAIT: begin
            if (sts.div_done) begin
               cmd.latch_nk = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!sts.changed) begin
               cmd.mac_clear = 1'b1;
               state_in      = S_MAC;
            end else if (sts.wrap_needed) begin
               cmd.mul_wrap = 1'b1;
               state_in     = S_DIV2_GO;
            end else if (sts.end_needed) begin
               cmd.stop_play = 1'b1;
               state_in      = S_OUT;
            end else begin
               cmd.rd_sample = 1'b1;
               state_in      = S_SHIFT;
            end
         end
         S_DIV2_GO: begin
            cmd.div_wrap = 1'b1;
            state_in     = S_DIV2_WAIT;
         end
         S_DIV2_WAIT: begin
            if (sts.div_done) begin
               cmd.apply_wrap = 1'b1;
               state_in       = S_MUL3;
            end
         end
         S_MUL3: begin
            cmd.mul_m = 1'b1;
            state_in  = S_DIV3_GO;
         end
         S_DIV3_GO: begin
            cmd.div_prod = 1'b1;
            state_in     = S_DIV3_WAIT;
         end
         S_DIV3_WAIT: begin
            if (sts.div_done) begin
               cmd.latch_k   = 1'b1;
               cmd.rd_sample = 1'b1;
               state_in      = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.shift_in  = 1'b1;
            cmd.mac_clear = 1'b1;
            state_in      = S_MAC;
         end
         S_MAC: begin
            if (sts.mac_done) begin
               cmd.scale = 1'b1;
               state_in  = S_FIN;
            end else begin
               cmd.mac_step = 1'b1;
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule

// ===== rtl/prs_dp.sv =====
// Datapath of the polyphase resampler: stores, indices, divider, MAC, output register.
// Depends on prs_pkg and prs_div.
module prs_dp #(
   parameter int TAPS           = prs_pkg::TAPS_DEFAULT,
   parameter int MAX_PHASES     = prs_pkg::MAX_PHASES_DEFAULT,
   parameter int SAMPLE_DEPTH   = prs_pkg::SAMPLE_DEPTH_DEFAULT,
   parameter int COEF_FRAC_BITS = prs_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  prs_pkg::cfg_type                    cfg,
   input  prs_pkg::dp_cmd_type                 cmd,
   input  logic [prs_pkg::ADDR_W-1:0]          ld_address,
   input  logic signed [prs_pkg::VALUE_W-1:0]  ld_value,
   input  logic                                out_ready,
   output prs_pkg::dp_sts_type                 sts,
   output logic                                out_valid,
   output logic signed [prs_pkg::VALUE_W-1:0]  out_sample,
   output logic                                out_active
);
   localparam int COEF_DEPTH = TAPS * MAX_PHASES;
   localparam int SAW   = $clog2(SAMPLE_DEPTH);
   localparam int CAW   = $clog2(COEF_DEPTH);
   localparam int TW    = $clog2(TAPS);
   localparam int CW    = $clog2(TAPS + 3);
   localparam int ACC_W = 2 * prs_pkg::VALUE_W + $clog2(TAPS) + 1;
   localparam int SC_W  = ACC_W + prs_pkg::PH_W + 1;
   localparam int VW    = prs_pkg::VALUE_W;

   // stores
   logic signed [VW-1:0] sample_mem [SAMPLE_DEPTH];
   logic signed [VW-1:0] coef_mem   [COEF_DEPTH];

   // effective ratio terms
   logic [prs_pkg::MSTEP_W-1:0] mm;
   logic [prs_pkg::PH_W-1:0]    l0, ll;

   always_comb begin
      mm = (cfg.decimation_step == '0) ? prs_pkg::MSTEP_W'(1) : cfg.decimation_step;
      l0 = (cfg.interpolation_phases == '0) ? prs_pkg::PH_W'(1)
                                            : prs_pkg::PH_W'(cfg.interpolation_phases);
      ll = (l0 > prs_pkg::PH_W'(MAX_PHASES)) ? prs_pkg::PH_W'(MAX_PHASES) : l0;
   end

   logic [prs_pkg::OIDX_W-1:0]  m_ff;
   logic [prs_pkg::IIDX_W-1:0]  iidx_ff;
   logic                        playing_ff;
   logic signed [VW-1:0]        delay_ff [TAPS];
   logic [prs_pkg::PROD_W-1:0]  prod_ff, n_ff;
   logic [prs_pkg::MSTEP_W-1:0] k_ff;
   logic [prs_pkg::WPROD_W-1:0] wprod_ff;
   logic                        wneg_ff;
   logic                        rd_ok_ff;
   logic signed [VW-1:0]        smp_rd_ff, coef_rd_ff, tap_ff;
   logic [CAW-1:0]              coef_addr_ff;
   logic signed [2*VW-1:0]      mprod_ff;
   logic                        v1_ff, v2_ff;
   logic [CW-1:0]               mac_cnt_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic signed [SC_W-1:0]      sc_ff;
   logic signed [VW-1:0]        res_sample_ff;
   logic                        res_active_ff;
   logic                        out_valid_ff;
   logic signed [VW-1:0]        out_sample_ff;
   logic                        out_active_ff;

   // divider
   logic                        div_start, div_done;
   logic [prs_pkg::PROD_W-1:0]  div_dividend, div_quo;
   logic [prs_pkg::MSTEP_W-1:0] div_divisor, div_rem;

   always_comb begin
      div_start    = cmd.div_prod | cmd.div_wrap;
      div_dividend = cmd.div_wrap ? prs_pkg::PROD_W'(wprod_ff) : prod_ff;
      div_divisor  = cmd.div_wrap ? mm : prs_pkg::MSTEP_W'(ll);
   end

   prs_div #(.DW(prs_pkg::PROD_W), .VW(prs_pkg::MSTEP_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // loop distance
   logic signed [prs_pkg::LOOP_W:0] diff;
   logic [prs_pkg::LOOP_W-1:0]      diff_mag;
   logic [31:0]                     ld_addr_w, n_addr_w;

   always_comb begin
      diff      = $signed({1'b0, cfg.loop_end}) - $signed({1'b0, cfg.loop_begin});
      diff_mag  = diff[prs_pkg::LOOP_W] ? prs_pkg::LOOP_W'(-diff) : diff[prs_pkg::LOOP_W-1:0];
      ld_addr_w = 32'(ld_address);
      n_addr_w  = 32'(n_ff);
   end

   // truncate toward zero, then saturate
   logic [SC_W-1:0]      sc_mag, sc_sh;
   logic signed [VW-1:0] sat_val;

   always_comb begin
      sc_mag = sc_ff[SC_W-1] ? SC_W'(-sc_ff) : SC_W'(sc_ff);
      sc_sh  = sc_mag >> COEF_FRAC_BITS;
      if (sc_ff[SC_W-1]) begin
         if (sc_sh > SC_W'(32768)) sat_val = VW'(-32768);
         else                      sat_val = VW'(-sc_sh);
      end else begin
         if (sc_sh > SC_W'(32767)) sat_val = VW'(32767);
         else                      sat_val = VW'(sc_sh);
      end
   end

   always_comb begin
      sts.playing     = playing_ff;
      sts.div_done    = div_done;
      sts.changed     = (n_ff[prs_pkg::IIDX_W-1:0] != iidx_ff);
      sts.wrap_needed = cfg.loop_mode && (n_ff > prs_pkg::PROD_W'(cfg.loop_end));
      sts.end_needed  = !cfg.loop_mode &&
                        ((cfg.sample_length == '0) ||
                         (n_ff >= prs_pkg::PROD_W'(cfg.sample_length) - 1'b1));
      sts.mac_done    = (mac_cnt_ff == CW'(TAPS + 2));
      sts.out_free    = !out_valid_ff || out_ready;
   end

   // stores
   always_ff @(posedge clock) begin
      if (cmd.ld_sample && ld_addr_w < 32'(SAMPLE_DEPTH))
         sample_mem[ld_addr_w[SAW-1:0]] <= ld_value;
      if (cmd.rd_sample)
         smp_rd_ff <= sample_mem[n_addr_w[SAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_coef && ld_addr_w < 32'(COEF_DEPTH))
         coef_mem[ld_addr_w[CAW-1:0]] <= ld_value;
      if (cmd.mac_step && mac_cnt_ff < CW'(TAPS))
         coef_rd_ff <= coef_mem[coef_addr_ff];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.mul_m)    prod_ff <= prs_pkg::PROD_W'(m_ff) * prs_pkg::PROD_W'(mm);
      if (cmd.latch_nk) begin
         n_ff <= div_quo;
         k_ff <= div_rem;
      end
      if (cmd.latch_k)  k_ff <= div_rem;
      if (cmd.mul_wrap) begin
         wneg_ff  <= diff[prs_pkg::LOOP_W];
         wprod_ff <= prs_pkg::WPROD_W'(diff_mag) * prs_pkg::WPROD_W'(ll);
      end
      if (cmd.rd_sample) rd_ok_ff <= (n_ff < prs_pkg::PROD_W'(SAMPLE_DEPTH));
      if (cmd.mac_clear) begin
         coef_addr_ff <= CAW'(k_ff);
         acc_ff       <= '0;
      end
      if (cmd.mac_step) begin
         if (mac_cnt_ff < CW'(TAPS)) begin
            tap_ff       <= delay_ff[mac_cnt_ff[TW-1:0]];
            coef_addr_ff <= coef_addr_ff + CAW'(ll);
         end
         mprod_ff <= coef_rd_ff * tap_ff;
         if (v2_ff) acc_ff <= acc_ff + ACC_W'(mprod_ff);
      end
      if (cmd.scale)
         sc_ff <= SC_W'(acc_ff) * SC_W'($signed({1'b0, ll}));
      if (cmd.finish) begin
         res_sample_ff <= sat_val;
         res_active_ff <= 1'b1;
      end
      if (cmd.stop_play || cmd.zero_res) begin
         res_sample_ff <= '0;
         res_active_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_sample_ff <= res_sample_ff;
         out_active_ff <= res_active_ff;
      end
   end

   // control and playback state
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         m_ff       <= '0;
         iidx_ff    <= '0;
         playing_ff <= 1'b1;
         for (int t = 0; t < TAPS; t++) delay_ff[t] <= '0;
      end else begin
         if (cmd.apply_wrap)
            m_ff <= wneg_ff ? m_ff + div_quo[prs_pkg::OIDX_W-1:0]
                            : m_ff - div_quo[prs_pkg::OIDX_W-1:0];
         if (cmd.finish) begin
            m_ff    <= m_ff + 1'b1;
            iidx_ff <= n_ff[prs_pkg::IIDX_W-1:0];
         end
         if (cmd.stop_play) playing_ff <= 1'b0;
         if (cmd.shift_in) begin
            for (int t = TAPS - 1; t >= 1; t--) delay_ff[t] <= delay_ff[t-1];
            delay_ff[0] <= rd_ok_ff ? smp_rd_ff : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         mac_cnt_ff   <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         if (cmd.out_load)     out_valid_ff <= 1'b1;
         else if (out_ready)   out_valid_ff <= 1'b0;
         if (cmd.mac_clear) begin
            mac_cnt_ff <= '0;
            v1_ff      <= 1'b0;
            v2_ff      <= 1'b0;
         end else if (cmd.mac_step) begin
            mac_cnt_ff <= mac_cnt_ff + 1'b1;
            v1_ff      <= (mac_cnt_ff < CW'(TAPS));
            v2_ff      <= v1_ff;
         end
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_sample = out_sample_ff;
   assign out_active = out_active_ff;
endmodule
